FILE: hdl/sht1x_pkg.sv
`timescale 1ns / 1ps

package sht1x_pkg;

  // Number of interface-reset clocks sent after power is applied.
  localparam int RESET_CLOCKS = 9;

  typedef enum logic [2:0] {
    OP_IDLE     = 3'd0,
    OP_RUN      = 3'd1,
    OP_WRITE_SR = 3'd2,
    OP_POWER_ON = 3'd3,
    OP_POWER_OFF = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    JOB_CMD = 2'd0,
    JOB_WSR = 2'd1,
    JOB_PON = 2'd2
  } job_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_TS0     = 5'd1,
    PH_TS1     = 5'd2,
    PH_TS2     = 5'd3,
    PH_TS3     = 5'd4,
    PH_TS4     = 5'd5,
    PH_TS5     = 5'd6,
    PH_TS6     = 5'd7,
    PH_CMD_LO  = 5'd8,
    PH_CMD_HI  = 5'd9,
    PH_CACK_LO = 5'd10,
    PH_CACK_HI = 5'd11,
    PH_VAL_LO  = 5'd12,
    PH_VAL_HI  = 5'd13,
    PH_VACK_LO = 5'd14,
    PH_VACK_HI = 5'd15,
    PH_WAIT    = 5'd16,
    PH_RB1_LO  = 5'd17,
    PH_RB1_HI  = 5'd18,
    PH_MACK_LO = 5'd19,
    PH_MACK_HI = 5'd20,
    PH_RB2_LO  = 5'd21,
    PH_RB2_HI  = 5'd22,
    PH_RI_LO   = 5'd23,
    PH_RI_HI   = 5'd24,
    PH_SETTLE  = 5'd25,
    PH_PWR_OFF = 5'd26,
    PH_END     = 5'd27
  } phase_t;

  typedef enum logic [2:0] {
    REG_CODE_TEMP   = 3'd0,
    REG_CODE_HUM    = 3'd1,
    REG_CODE_RD_SR  = 3'd2,
    REG_CODE_WR_SR  = 3'd3,
    REG_CODE_SOFT   = 3'd4,
    REG_SETTLE      = 3'd5
  } reg_idx_t;

  // Transmission-start pattern, one entry per step: clock and data levels.
  localparam logic [6:0] TS_CLK = 7'b0110110; // bit k is step k
  localparam logic [6:0] TS_DAT = 7'b1110011;

endpackage

FILE: hdl/sht1x_two_wire_master_core.sv
`timescale 1ns / 1ps

// Pin-level master for the two-wire link of a humidity and temperature sensor. Every input
// beat is one pin-update tick carrying a request opcode and the sampled data pin; every tick
// yields exactly one result beat with the clock, data and power pin levels and the status.
// The tick is worked out by the sequencer logic between the input handshake and the result
// register, so the block takes one beat per clock cycle and each result appears in the
// result register in the cycle after its input beat is accepted; the result register alone
// decides the rate, and a new beat is taken whenever that register is empty or being read.
// A run request sends the start pattern and the command byte, most significant bit first,
// and samples the acknowledge; measurement commands then wait for data low, with no timeout,
// and read two bytes, while a status read takes one byte. A status write sends a second byte;
// a missing acknowledge there power-cycles the sensor. Power-on applies power, sends the
// interface-reset clocks, waits out settle_ticks and sends the soft-reset command. A missing
// acknowledge reports fail with result 0xFFFF. Requests that arrive while busy_res is high are
// ignored. The command codes and settle time sit in APB registers at byte addresses 0 to 20.
module sht1x_two_wire_master_core
  import sht1x_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tick input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  command,
  input  logic [7:0]  write_value,
  input  logic        data_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        sclk,
  output logic        data_drive,
  output logic        data_level,
  output logic        power_enable,
  output logic        busy_res,
  output logic        done_res,
  output logic        fail,
  output logic [15:0] result
);

  // Configuration registers.
  logic [7:0]  code_read_temperature;
  logic [7:0]  code_read_humidity;
  logic [7:0]  code_read_status;
  logic [7:0]  code_write_status;
  logic [7:0]  code_soft_reset;
  logic [19:0] settle_ticks;

  logic     cfg_write;
  reg_idx_t cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_read_temperature <= 8'd3;
      code_read_humidity    <= 8'd5;
      code_read_status      <= 8'd7;
      code_write_status     <= 8'd6;
      code_soft_reset       <= 8'd30;
      settle_ticks          <= 20'd11000;
    end else if (cfg_write) begin
      // Addresses beyond the last register are ignored.
      unique case (cfg_idx)
        REG_CODE_TEMP:  code_read_temperature <= pwdata[7:0];
        REG_CODE_HUM:   code_read_humidity    <= pwdata[7:0];
        REG_CODE_RD_SR: code_read_status      <= pwdata[7:0];
        REG_CODE_WR_SR: code_write_status     <= pwdata[7:0];
        REG_CODE_SOFT:  code_soft_reset       <= pwdata[7:0];
        REG_SETTLE:     settle_ticks          <= pwdata[19:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CODE_TEMP:  prdata = {24'd0, code_read_temperature};
      REG_CODE_HUM:   prdata = {24'd0, code_read_humidity};
      REG_CODE_RD_SR: prdata = {24'd0, code_read_status};
      REG_CODE_WR_SR: prdata = {24'd0, code_write_status};
      REG_CODE_SOFT:  prdata = {24'd0, code_soft_reset};
      REG_SETTLE:     prdata = {12'd0, settle_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  // Sequencer state.
  phase_t      phase, phase_next, step_phase;
  logic [3:0]  bit_count, bit_count_next;
  logic [15:0] shift_word, shift_word_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_write_value, held_write_value_next;
  logic [19:0] wait_count, wait_count_next;
  logic        power_state, power_state_next;
  job_t        job, job_next;
  logic        failed, failed_next;

  // Pin and status values of the current tick.
  logic        tick_clk, tick_drv, tick_lvl, tick_done, tick_fail;
  logic [15:0] tick_res;
  logic        skip_step;
  logic [2:0]  ts_step;
  logic        in_accept;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign ts_step   = 3'(step_phase - PH_TS0);

  // Next state: a request taken in idle also drives its first step on the same tick.
  always_comb begin
    phase_next            = phase;
    bit_count_next        = bit_count;
    shift_word_next       = shift_word;
    held_command_next     = held_command;
    held_write_value_next = held_write_value;
    wait_count_next       = wait_count;
    power_state_next      = power_state;
    job_next              = job;
    failed_next           = failed;
    skip_step             = 1'b0;

    if (phase == PH_IDLE) begin
      if (opcode == OP_RUN) begin
        held_command_next = command;
        job_next = JOB_CMD; failed_next = 1'b0; bit_count_next = 4'd0; phase_next = PH_TS0;
      end else if (opcode == OP_WRITE_SR) begin
        held_command_next     = code_write_status;
        held_write_value_next = write_value;
        job_next = JOB_WSR; failed_next = 1'b0; bit_count_next = 4'd0; phase_next = PH_TS0;
      end else if (opcode == OP_POWER_ON) begin
        held_command_next = code_soft_reset;
        job_next = JOB_PON; failed_next = 1'b0; bit_count_next = 4'd0; phase_next = PH_RI_LO;
      end else if (opcode == OP_POWER_OFF) begin
        power_state_next = 1'b0;
        skip_step        = 1'b1;
      end else begin
        skip_step = 1'b1;
      end
    end

    step_phase = phase_next;

    if (!skip_step) begin
      unique case (step_phase)
        PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5, PH_TS6: begin
          phase_next = (step_phase == PH_TS6) ? PH_CMD_LO : phase_t'(step_phase + 5'd1);
          bit_count_next = 4'd0;
        end
        PH_CMD_LO: phase_next = PH_CMD_HI;
        PH_CMD_HI: begin
          if (bit_count >= 4'd7) begin
            bit_count_next = 4'd0; phase_next = PH_CACK_LO;
          end else begin
            bit_count_next = bit_count + 4'd1; phase_next = PH_CMD_LO;
          end
        end
        PH_CACK_LO: phase_next = PH_CACK_HI;
        PH_VACK_LO: phase_next = PH_VACK_HI;
        PH_CACK_HI: begin
          bit_count_next = 4'd0;
          if (data_in) begin
            failed_next = 1'b1;
            phase_next  = (job == JOB_WSR) ? PH_PWR_OFF : PH_END;
          end else if (job == JOB_WSR) begin
            phase_next = PH_VAL_LO;
          end else begin
            shift_word_next = 16'd0;
            // Measurement codes take priority over the status read code.
            if (held_command == code_read_temperature || held_command == code_read_humidity)
              phase_next = PH_WAIT;
            else if (held_command == code_read_status)
              phase_next = PH_RB2_LO;
            else
              phase_next = PH_END;
          end
        end
        PH_VAL_LO: phase_next = PH_VAL_HI;
        PH_VAL_HI: begin
          if (bit_count >= 4'd7) begin
            bit_count_next = 4'd0; phase_next = PH_VACK_LO;
          end else begin
            bit_count_next = bit_count + 4'd1; phase_next = PH_VAL_LO;
          end
        end
        PH_VACK_HI: begin
          if (data_in) begin
            failed_next = 1'b1; phase_next = PH_PWR_OFF;
          end else begin
            shift_word_next = 16'd0; phase_next = PH_END;
          end
        end
        PH_WAIT: begin
          // The sensor pulls data low once the measurement is ready.
          if (!data_in) begin
            bit_count_next = 4'd0; phase_next = PH_RB1_HI;
          end
        end
        PH_RB1_LO: phase_next = PH_RB1_HI;
        PH_RB2_LO: phase_next = PH_RB2_HI;
        PH_RB1_HI, PH_RB2_HI: begin
          shift_word_next = {shift_word[14:0], data_in};
          if (bit_count >= 4'd7) begin
            bit_count_next = 4'd0;
            phase_next = (step_phase == PH_RB1_HI) ? PH_MACK_LO : PH_END;
          end else begin
            bit_count_next = bit_count + 4'd1;
            phase_next = (step_phase == PH_RB1_HI) ? PH_RB1_LO : PH_RB2_LO;
          end
        end
        PH_MACK_LO: phase_next = PH_MACK_HI;
        PH_MACK_HI: begin
          bit_count_next = 4'd0; phase_next = PH_RB2_LO;
        end
        PH_RI_LO: begin
          power_state_next = 1'b1; phase_next = PH_RI_HI;
        end
        PH_RI_HI: begin
          if (bit_count >= 4'(RESET_CLOCKS - 1)) begin
            bit_count_next  = 4'd0;
            wait_count_next = settle_ticks;
            phase_next = (settle_ticks != 20'd0) ? PH_SETTLE : PH_TS0;
          end else begin
            bit_count_next = bit_count + 4'd1; phase_next = PH_RI_LO;
          end
        end
        PH_SETTLE: begin
          wait_count_next = (wait_count != 20'd0) ? wait_count - 20'd1 : 20'd0;
          if (wait_count <= 20'd1)
            phase_next = PH_TS0;
        end
        PH_PWR_OFF: begin
          power_state_next  = 1'b0;
          held_command_next = code_soft_reset;
          job_next = JOB_PON; bit_count_next = 4'd0; phase_next = PH_RI_LO;
        end
        PH_END: phase_next = PH_IDLE;
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Pin levels and status of the step driven on this tick. A power-off request finishes at
  // once and never reports a failure, whatever the previous sequence left behind.
  always_comb begin
    tick_clk  = 1'b0;
    tick_drv  = 1'b0;
    tick_lvl  = 1'b1;
    tick_done = 1'b0;
    tick_fail = 1'b0;
    tick_res  = 16'd0;

    if (phase == PH_IDLE && opcode == OP_POWER_OFF)
      tick_done = 1'b1;

    if (!skip_step) begin
      unique case (step_phase)
        PH_TS0, PH_TS1, PH_TS2, PH_TS3, PH_TS4, PH_TS5, PH_TS6: begin
          tick_clk = TS_CLK[ts_step];
          tick_drv = 1'b1;
          tick_lvl = TS_DAT[ts_step];
        end
        PH_CMD_LO: begin
          tick_drv = 1'b1; tick_lvl = held_command[~bit_count[2:0]];
        end
        PH_CMD_HI: begin
          tick_clk = 1'b1; tick_drv = 1'b1; tick_lvl = held_command[~bit_count[2:0]];
        end
        PH_VAL_LO: begin
          tick_drv = 1'b1; tick_lvl = held_write_value[~bit_count[2:0]];
        end
        PH_VAL_HI: begin
          tick_clk = 1'b1; tick_drv = 1'b1; tick_lvl = held_write_value[~bit_count[2:0]];
        end
        PH_CACK_HI, PH_VACK_HI, PH_RB1_HI, PH_RB2_HI: tick_clk = 1'b1;
        PH_MACK_LO: begin
          tick_drv = 1'b1; tick_lvl = 1'b0;
        end
        PH_MACK_HI: begin
          tick_clk = 1'b1; tick_drv = 1'b1; tick_lvl = 1'b0;
        end
        PH_RI_LO, PH_SETTLE: begin
          tick_drv = 1'b1; tick_lvl = 1'b1;
        end
        PH_RI_HI: begin
          tick_clk = 1'b1; tick_drv = 1'b1; tick_lvl = 1'b1;
        end
        PH_END: begin
          tick_done = 1'b1;
          tick_fail = failed;
          tick_res  = failed ? 16'hFFFF : shift_word;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bit_count        <= 4'd0;
      shift_word       <= 16'd0;
      held_command     <= 8'd0;
      held_write_value <= 8'd0;
      wait_count       <= 20'd0;
      power_state      <= 1'b0;
      job              <= JOB_CMD;
      failed           <= 1'b0;
    end else if (in_accept) begin
      phase            <= phase_next;
      bit_count        <= bit_count_next;
      shift_word       <= shift_word_next;
      held_command     <= held_command_next;
      held_write_value <= held_write_value_next;
      wait_count       <= wait_count_next;
      power_state      <= power_state_next;
      job              <= job_next;
      failed           <= failed_next;
    end
  end

  // Result register: one beat out for every beat in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sclk         <= tick_clk;
      data_drive   <= tick_drv;
      data_level   <= tick_drv ? tick_lvl : 1'b1;
      power_enable <= power_state_next;
      busy_res     <= (phase_next != PH_IDLE);
      done_res     <= tick_done;
      fail         <= tick_fail;
      result       <= tick_done ? tick_res : 16'd0;
    end
  end

  // A finishing beat always leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // Fail is only reported on a finishing beat, and then with the failure code.
  a_fail_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && fail |-> done_res && result == 16'hFFFF)
    else $error("fail without done or without failure code");

  // A released data pin reads back as a high level.
  a_release_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_drive |-> data_level)
    else $error("data level low while released");

  // A beat that is taken while the result waits never overwrites it.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken over a pending result");

endmodule

FILE: tb/sht1x_two_wire_master_core_tb.sv
`timescale 1ns / 1ps

module sht1x_two_wire_master_core_tb;
  import sht1x_pkg::*;

  // Opcodes 5 to 7 have no meaning and must behave as idle ticks.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Hard stop for the whole run.
  localparam int CYCLE_LIMIT = 500000;

  // One result beat as seen on the pins, in port order.
  typedef struct packed {
    logic        sclk;
    logic        data_drive;
    logic        data_level;
    logic        power_enable;
    logic        busy;
    logic        done;
    logic        fail;
    logic [15:0] result;
  } pin_beat_t;

  // The scoreboard keeps its own copy of the sequencer and of the command registers.
  // Every accepted tick is stepped through that copy and the predicted pin beat is
  // queued; every result beat is compared against the oldest queued prediction.
  class sht1x_pin_scoreboard;
    logic [7:0]  code_temp, code_hum, code_rd_sr, code_wr_sr, code_soft;
    logic [19:0] settle;
    phase_t      phase;
    job_t        job;
    logic [3:0]  bit_count;
    logic [15:0] shift_word;
    logic [7:0]  held_cmd, held_val;
    logic [19:0] wait_left;
    logic        powered;
    logic        failed;
    pin_beat_t   pending[$];
    int          mismatches;

    function new();
      code_temp  = 8'd3;
      code_hum   = 8'd5;
      code_rd_sr = 8'd7;
      code_wr_sr = 8'd6;
      code_soft  = 8'd30;
      settle     = 20'd11000;
      phase      = PH_IDLE;
      job        = JOB_CMD;
      bit_count  = '0;
      shift_word = '0;
      held_cmd   = '0;
      held_val   = '0;
      wait_left  = '0;
      powered    = 1'b0;
      failed     = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_CODE_TEMP:  code_temp  = value[7:0];
        REG_CODE_HUM:   code_hum   = value[7:0];
        REG_CODE_RD_SR: code_rd_sr = value[7:0];
        REG_CODE_WR_SR: code_wr_sr = value[7:0];
        REG_CODE_SOFT:  code_soft  = value[7:0];
        REG_SETTLE:     settle     = value[19:0];
        default: ;
      endcase
    endfunction

    function void begin_job(job_t kind, phase_t first);
      job       = kind;
      failed    = 1'b0;
      bit_count = '0;
      phase     = first;
    endfunction

    // Steps the bit counter; true once the last bit of the group has gone.
    function bit last_bit(logic [3:0] last);
      if (bit_count >= last) begin
        bit_count = '0;
        return 1'b1;
      end
      bit_count = bit_count + 4'd1;
      return 1'b0;
    endfunction

    function void note_tick(logic [2:0] op, logic [7:0] cmd, logic [7:0] wval, logic din);
      pin_beat_t   b;
      logic        c_l, drv, lvl, fin;
      logic [15:0] word;
      bit          settled;
      int          k;
      c_l = 1'b0;
      drv = 1'b0;
      lvl = 1'b1;
      fin = 1'b0;
      word = '0;
      settled = 1'b0;
      if (phase == PH_IDLE) begin
        settled = 1'b1;
        case (op)
          OP_RUN: begin
            held_cmd = cmd;
            begin_job(JOB_CMD, PH_TS0);
            settled = 1'b0;
          end
          OP_WRITE_SR: begin
            held_cmd = code_wr_sr;
            held_val = wval;
            begin_job(JOB_WSR, PH_TS0);
            settled = 1'b0;
          end
          OP_POWER_ON: begin
            held_cmd = code_soft;
            begin_job(JOB_PON, PH_RI_LO);
            settled = 1'b0;
          end
          OP_POWER_OFF: begin
            powered = 1'b0;
            fin = 1'b1;
          end
          default: ;
        endcase
      end
      if (!settled) begin
        if (phase >= PH_TS0 && phase <= PH_TS6) begin
          k = phase - PH_TS0;
          c_l = TS_CLK[k];
          drv = 1'b1;
          lvl = TS_DAT[k];
          phase = (phase == PH_TS6) ? PH_CMD_LO : phase_t'(phase + 1);
          bit_count = '0;
        end else begin
          case (phase)
            PH_CMD_LO: begin
              drv = 1'b1;
              lvl = held_cmd[3'd7 - bit_count[2:0]];
              phase = PH_CMD_HI;
            end
            PH_CMD_HI: begin
              c_l = 1'b1;
              drv = 1'b1;
              lvl = held_cmd[3'd7 - bit_count[2:0]];
              phase = last_bit(4'd7) ? PH_CACK_LO : PH_CMD_LO;
            end
            PH_CACK_LO, PH_VACK_LO, PH_RB1_LO, PH_RB2_LO: phase = phase_t'(phase + 1);
            PH_CACK_HI: begin
              c_l = 1'b1;
              bit_count = '0;
              if (din) begin
                failed = 1'b1;
                phase = (job == JOB_WSR) ? PH_PWR_OFF : PH_END;
              end else if (job == JOB_WSR) begin
                phase = PH_VAL_LO;
              end else begin
                shift_word = '0;
                if (held_cmd == code_temp || held_cmd == code_hum) phase = PH_WAIT;
                else if (held_cmd == code_rd_sr) phase = PH_RB2_LO;
                else phase = PH_END;
              end
            end
            PH_VAL_LO: begin
              drv = 1'b1;
              lvl = held_val[3'd7 - bit_count[2:0]];
              phase = PH_VAL_HI;
            end
            PH_VAL_HI: begin
              c_l = 1'b1;
              drv = 1'b1;
              lvl = held_val[3'd7 - bit_count[2:0]];
              phase = last_bit(4'd7) ? PH_VACK_LO : PH_VAL_LO;
            end
            PH_VACK_HI: begin
              c_l = 1'b1;
              if (din) begin
                failed = 1'b1;
                phase = PH_PWR_OFF;
              end else begin
                shift_word = '0;
                phase = PH_END;
              end
            end
            PH_WAIT: begin
              if (!din) begin
                bit_count = '0;
                phase = PH_RB1_HI;
              end
            end
            PH_RB1_HI, PH_RB2_HI: begin
              c_l = 1'b1;
              shift_word = {shift_word[14:0], din};
              if (last_bit(4'd7)) phase = (phase == PH_RB1_HI) ? PH_MACK_LO : PH_END;
              else phase = phase_t'(phase - 1);
            end
            PH_MACK_LO: begin
              drv = 1'b1;
              lvl = 1'b0;
              phase = PH_MACK_HI;
            end
            PH_MACK_HI: begin
              c_l = 1'b1;
              drv = 1'b1;
              lvl = 1'b0;
              bit_count = '0;
              phase = PH_RB2_LO;
            end
            PH_RI_LO: begin
              powered = 1'b1;
              drv = 1'b1;
              lvl = 1'b1;
              phase = PH_RI_HI;
            end
            PH_RI_HI: begin
              c_l = 1'b1;
              drv = 1'b1;
              lvl = 1'b1;
              if (last_bit(4'(RESET_CLOCKS - 1))) begin
                wait_left = settle;
                phase = (wait_left != 0) ? PH_SETTLE : PH_TS0;
              end else begin
                phase = PH_RI_LO;
              end
            end
            PH_SETTLE: begin
              drv = 1'b1;
              lvl = 1'b1;
              if (wait_left != 0) wait_left = wait_left - 20'd1;
              if (wait_left == 0) phase = PH_TS0;
            end
            PH_PWR_OFF: begin
              powered = 1'b0;
              held_cmd = code_soft;
              job = JOB_PON;
              bit_count = '0;
              phase = PH_RI_LO;
            end
            PH_END: begin
              fin = 1'b1;
              word = failed ? 16'hFFFF : shift_word;
              phase = PH_IDLE;
            end
            default: phase = PH_IDLE;
          endcase
        end
      end
      b.sclk         = c_l;
      b.data_drive   = drv;
      b.data_level   = drv ? lvl : 1'b1;
      b.power_enable = powered;
      b.busy         = (phase != PH_IDLE);
      b.done         = fin;
      // A power-off request reports done with no failure, whatever went before.
      b.fail         = fin && !settled && failed;
      b.result       = fin ? word : 16'h0000;
      pending.push_back(b);
    endfunction

    function void report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endfunction

    function void check_pins(pin_beat_t got);
      pin_beat_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (%h)", got));
        return;
      end
      want = pending.pop_front();
      if (got.sclk !== want.sclk)
        report_mismatch($sformatf("sclk %b, expected %b", got.sclk, want.sclk));
      if (got.data_drive !== want.data_drive)
        report_mismatch($sformatf("data_drive %b, expected %b", got.data_drive, want.data_drive));
      if (got.data_level !== want.data_level)
        report_mismatch($sformatf("data_level %b, expected %b", got.data_level, want.data_level));
      if (got.power_enable !== want.power_enable)
        report_mismatch($sformatf("power_enable %b, expected %b",
                                  got.power_enable, want.power_enable));
      if (got.busy !== want.busy)
        report_mismatch($sformatf("busy_res %b, expected %b", got.busy, want.busy));
      if (got.done !== want.done)
        report_mismatch($sformatf("done_res %b, expected %b", got.done, want.done));
      if (got.fail !== want.fail)
        report_mismatch($sformatf("fail %b, expected %b", got.fail, want.fail));
      if (got.result !== want.result)
        report_mismatch($sformatf("result %h, expected %h", got.result, want.result));
    endfunction
  endclass

  // Every input of the block starts at a known level; reset is held from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = OP_IDLE;
  logic [7:0]  command = '0;
  logic [7:0]  write_value = '0;
  logic        data_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        sclk, data_drive, data_level, power_enable, busy_res, done_res, fail;
  logic [15:0] result;

  sht1x_pin_scoreboard sb;

  // Idle and stall rates for the two sides, changed between the stages of the run, and
  // counters for the calm stretches during which a side does not hold back.
  int send_idle_pct = 38;
  int recv_stall_pct = 46;
  int tx_calm = 0;
  int rx_calm = 0;
  int cycles = 0;

  // How the imitated sensor answers. In scripted mode each request is given a fixed
  // acknowledge, a fixed number of busy ticks before the measurement is ready and a fixed
  // data word; in random mode the answers are drawn, mostly well behaved.
  bit          random_reply = 1'b0;
  logic        nack_cmd = 1'b0;
  logic        nack_val = 1'b0;
  int          hold_left = 0;
  logic [15:0] reply_word = '0;

  always #1 clk = ~clk;

  sht1x_two_wire_master_core u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .command      (command),
    .write_value  (write_value),
    .data_in      (data_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sclk         (sclk),
    .data_drive   (data_drive),
    .data_level   (data_level),
    .power_enable (power_enable),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .fail         (fail),
    .result       (result)
  );

  // The run is abandoned once the cycle budget is spent; a hang counts as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sht1x_two_wire_master_core_tb: done, errors");
      $finish;
    end
  end

  // Result side. Beats are sampled at the rising edge, before this edge's updates land,
  // and out_ready is redrawn for the next cycle. Short calm stretches keep the receiver
  // from stalling at all for a while, so back-to-back beats are seen too.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_pins({sclk, data_drive, data_level, power_enable, busy_res, done_res, fail,
                       result});
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(99) < 3) rx_calm = $urandom_range(60, 20);
      out_ready <= (rx_calm != 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Level of the data pin that the sensor would present on the coming tick. It is worked
  // out from the predicted phase, so that acknowledge, ready and data bits land on the
  // ticks that sample them.
  function automatic logic sensor_pin();
    logic pin;
    pin = 1'($urandom_range(1));
    if (random_reply) begin
      case (sb.phase)
        PH_CACK_HI, PH_VACK_HI: pin = ($urandom_range(99) < 12);
        PH_WAIT:                pin = ($urandom_range(99) < 65);
        default: ;
      endcase
    end else begin
      case (sb.phase)
        PH_CACK_HI: pin = nack_cmd;
        PH_VACK_HI: pin = nack_val;
        PH_WAIT: begin
          pin = (hold_left > 0);
          if (hold_left > 0) hold_left--;
        end
        PH_RB1_HI: pin = reply_word[4'd15 - sb.bit_count];
        PH_RB2_HI: pin = reply_word[4'd7 - sb.bit_count];
        default: ;
      endcase
    end
    return pin;
  endfunction

  // Offers one tick beat, after a random number of idle cycles, and holds it until it is
  // taken. The beat is stepped through the scoreboard at the edge that accepts it. in_valid
  // is left high afterwards; the next call either keeps it high or drops it.
  task automatic send_tick(logic [2:0] op, logic [7:0] cmd, logic [7:0] wval, logic din);
    if (tx_calm > 0) tx_calm--;
    else if ($urandom_range(99) < 3) tx_calm = $urandom_range(60, 20);
    if (tx_calm == 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    command     <= cmd;
    write_value <= wval;
    data_in     <= din;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(op, cmd, wval, din);
  endtask

  // Keeps ticking with random requests, which the busy sequencer must ignore, until the
  // predicted sequencer is back at rest.
  task automatic finish_sequence();
    while (sb.phase != PH_IDLE)
      send_tick(3'($urandom_range(OP_SPARE_LAST, OP_IDLE)), 8'($urandom_range(255)),
                8'($urandom_range(255)), sensor_pin());
  endtask

  // Runs one request with a scripted sensor from its first tick until the sequencer is at rest.
  task automatic do_request(logic [2:0] op, logic [7:0] cmd, logic [7:0] wval,
                            logic nc, logic nv, int hold, logic [15:0] word);
    random_reply = 1'b0;
    nack_cmd     = nc;
    nack_val     = nv;
    hold_left    = hold;
    reply_word   = word;
    send_tick(op, cmd, wval, sensor_pin());
    finish_sequence();
  endtask

  // Drops the tick channel and waits until every predicted beat has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Rewrites every register. Only called with the sequencer at rest and nothing in flight.
  task automatic configure(logic [7:0] temp_code, logic [7:0] hum_code, logic [7:0] rd_code,
                           logic [7:0] wr_code, logic [7:0] soft_code, logic [19:0] wait_ticks);
    wait_drained();
    apb_write(REG_CODE_TEMP, {24'h0, temp_code});
    apb_write(REG_CODE_HUM, {24'h0, hum_code});
    apb_write(REG_CODE_RD_SR, {24'h0, rd_code});
    apb_write(REG_CODE_WR_SR, {24'h0, wr_code});
    apb_write(REG_CODE_SOFT, {24'h0, soft_code});
    apb_write(REG_SETTLE, {12'h0, wait_ticks});
  endtask

  // Random traffic. While the sequencer rests, a request is drawn: commands, mostly aimed
  // at the programmed codes, with status writes, power cycling, plain idle ticks and the
  // spare opcodes mixed in. While it is busy the opcode is noise that must be ignored.
  task automatic random_ticks(int count);
    logic [2:0] op;
    logic [7:0] cmd;
    int         pick;
    random_reply = 1'b1;
    for (int i = 0; i < count; i++) begin
      op  = 3'($urandom_range(OP_SPARE_LAST, OP_IDLE));
      cmd = 8'($urandom_range(255));
      if (sb.phase == PH_IDLE) begin
        pick = $urandom_range(99);
        if (pick < 45) op = OP_RUN;
        else if (pick < 63) op = OP_WRITE_SR;
        else if (pick < 72) op = OP_POWER_ON;
        else if (pick < 80) op = OP_POWER_OFF;
        else if (pick < 90) op = OP_IDLE;
        else op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        case ($urandom_range(9))
          0, 1, 2: cmd = sb.code_temp;
          3, 4:    cmd = sb.code_hum;
          5, 6:    cmd = sb.code_rd_sr;
          7:       cmd = sb.code_soft;
          8:       cmd = sb.code_wr_sr;
          default: ;
        endcase
      end
      send_tick(op, cmd, 8'($urandom_range(255)), sensor_pin());
    end
    finish_sequence();
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset codes. The settle time is still long here, so nothing
    // that powers the sensor up is asked for until it has been shortened.
    do_request(OP_POWER_OFF, 8'h00, 8'h00, 1'b0, 1'b0, 0, 16'h0000);
    do_request(OP_IDLE, 8'hFF, 8'hFF, 1'b0, 1'b0, 0, 16'h0000);
    do_request(OP_SPARE_FIRST, 8'h03, 8'h00, 1'b0, 1'b0, 0, 16'h0000);
    do_request(OP_SPARE_LAST, 8'h05, 8'h00, 1'b0, 1'b0, 0, 16'h0000);
    do_request(OP_RUN, 8'd3, 8'h00, 1'b0, 1'b0, 3, 16'hA5C3);
    do_request(OP_RUN, 8'd5, 8'h00, 1'b0, 1'b0, 0, 16'h0000);
    do_request(OP_RUN, 8'd7, 8'h00, 1'b0, 1'b0, 0, 16'h00FF);
    do_request(OP_WRITE_SR, 8'h00, 8'hFF, 1'b0, 1'b0, 0, 16'h0000);
    // A code that matches no measurement or status read finishes with a zero result.
    do_request(OP_RUN, 8'hFF, 8'h00, 1'b0, 1'b0, 0, 16'h0000);
    // The sensor stays silent on the command byte.
    do_request(OP_RUN, 8'd3, 8'h00, 1'b1, 1'b0, 0, 16'h1234);

    // Extreme codes and no settle wait at all.
    configure(8'h00, 8'hFF, 8'h80, 8'h01, 8'hFF, 20'd0);
    do_request(OP_POWER_ON, 8'h00, 8'h00, 1'b0, 1'b0, 0, 16'h0000);
    // Powering up again while already on, with the soft reset left unacknowledged.
    do_request(OP_POWER_ON, 8'h00, 8'h00, 1'b1, 1'b0, 0, 16'h0000);
    do_request(OP_RUN, 8'h00, 8'h00, 1'b0, 1'b0, 5, 16'hFFFF);
    do_request(OP_RUN, 8'hFF, 8'h00, 1'b0, 1'b0, 1, 16'h1234);
    do_request(OP_RUN, 8'h80, 8'h00, 1'b0, 1'b0, 0, 16'h5A5A);
    // A status write whose value byte goes unacknowledged power-cycles the sensor; so does
    // one whose command byte is refused.
    do_request(OP_WRITE_SR, 8'h00, 8'h00, 1'b0, 1'b1, 0, 16'h0000);
    do_request(OP_WRITE_SR, 8'h00, 8'hA5, 1'b1, 1'b0, 0, 16'h0000);

    // All codes but the status write equal, the soft reset included, so the temperature match
    // wins everywhere and the power-up sequence ends in a full measurement. One settle tick.
    configure(8'h42, 8'h42, 8'h42, 8'hFE, 8'h42, 20'd1);
    do_request(OP_RUN, 8'h42, 8'h00, 1'b0, 1'b0, 2, 16'hC3A5);
    do_request(OP_POWER_ON, 8'h00, 8'h00, 1'b0, 1'b0, 1, 16'h8001);
    do_request(OP_WRITE_SR, 8'h00, 8'h3C, 1'b0, 1'b1, 0, 16'h7FFE);
    // With the supply off the command still runs, and the silent sensor fails it.
    do_request(OP_POWER_OFF, 8'h00, 8'h00, 1'b0, 1'b0, 0, 16'h0000);
    do_request(OP_RUN, 8'h42, 8'h00, 1'b1, 1'b0, 0, 16'h0000);

    // Longest settle time, with only requests that never reach the power-up sequence.
    configure(8'd3, 8'd5, 8'd7, 8'd6, 8'd30, 20'hFFFFF);
    do_request(OP_RUN, 8'd5, 8'h00, 1'b0, 1'b0, 0, 16'h0F0F);
    do_request(OP_RUN, 8'd7, 8'h00, 1'b0, 1'b0, 0, 16'h0081);

    // Random part: three idling regimes, each with two register settings.
    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct  = (stage == 0) ? 38 : (stage == 1) ? 46 : 0;
      recv_stall_pct = (stage == 0) ? 46 : (stage == 1) ? 38 : 0;
      for (int half = 0; half < 2; half++) begin
        configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)), 20'($urandom_range(8)));
        random_ticks(175);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("sht1x_two_wire_master_core_tb: done, clean");
    end else begin
      $display("sht1x_two_wire_master_core_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sht1x_pkg.sv
hdl/sht1x_two_wire_master_core.sv
tb/sht1x_two_wire_master_core_tb.sv
